### src/rssc_pkg.sv
// Shared types and constants of the RLE sprite span clipper.
// Used by the front, queue, back and top-level modules.
`default_nettype none

package rssc_pkg;

  localparam int unsigned CoordBits  = 16;
  localparam int unsigned PosBits    = 19;
  localparam int unsigned SumBits    = PosBits + 1;
  localparam int unsigned SizeBits   = 12;
  localparam int unsigned LayerBits  = 8;
  localparam int unsigned WinBits    = 13;
  localparam int unsigned RowBits    = 12;
  localparam int unsigned SrcBits    = 16;
  localparam int unsigned InDataBits  = 120;
  localparam int unsigned OutDataBits = 64;

  localparam logic [RowBits-1:0]          RowMax      = 12'd4095;
  localparam logic signed [SumBits-1:0]   CursorMax   = 20'sd131071;
  localparam logic [SizeBits:0]           HeaderWords = 13'd2;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_RUN   = 1'b1
  } item_kind_e;

  typedef enum logic {
    CFG_WINDOW_WIDTH  = 1'b0,
    CFG_WINDOW_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    item_kind_e                 kind;
    logic signed [PosBits-1:0]  off_x;
    logic signed [PosBits-1:0]  off_y;
    logic signed [PosBits-1:0]  ext_x;
    logic signed [PosBits-1:0]  ext_y;
    logic [LayerBits-1:0]       layer;
    logic [SizeBits-1:0]        skip;
    logic [SizeBits-1:0]        opq;
    logic [SizeBits:0]          sum;
    logic                       row_end;
  } rssc_entry_t;

  typedef struct packed {
    logic [RowBits-1:0]   span_y;
    logic [WinBits-1:0]   x_start;
    logic [WinBits-1:0]   x_end;
    logic [SrcBits-1:0]   source_word;
    logic [LayerBits-1:0] layer;
  } rssc_span_t;

endpackage

`default_nettype wire

### src/rle_sprite_span_clipper.sv
// Top level of the RLE sprite span clipper: ports, window registers, front, queue, back.
// Depends on rssc_pkg, rssc_front, rssc_queue and rssc_back.
//
// The block takes one input transaction per cycle while the queue has room and the
// master side takes its spans; a span passes the queue and the back end's output
// register before the master side sees it. The back end's cursor update sets the rate:
// it retires one queued entry per cycle unless a held output span stalls it. A start
// transaction (tuser 0) sets placement, clip bounds and layer; each run entry (tuser 1,
// tlast at row end) yields at most one span. Clip bounds latched at a start transaction
// use the window size at that time; the span end clamp uses the current window width.
`default_nettype none

module rle_sprite_span_clipper
  import rssc_pkg::*;
#(
  parameter int unsigned WORD_OFFSET_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // tdata: screen_x, screen_y, origin_x, origin_y, sprite_width, sprite_height,
  //        layer, skip_len, opaque_len
  input  wire logic [InDataBits-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tuser,   // kind
  input  wire logic                   s_axis_tlast,   // row_end
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: span_y, span_x_start, span_x_end, source_word, span_layer, zero pad
  output logic [OutDataBits-1:0]      m_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic                   cfg_index_i,
  input  wire logic [WinBits-1:0]     cfg_data_i
);

  logic [WinBits-1:0] window_width_q, window_height_q;
  rssc_entry_t        front_entry, queue_entry;
  logic               queue_full, queue_valid, pop;
  rssc_span_t         span;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_width_q  <= 13'd320;
      window_height_q <= 13'd200;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_WINDOW_WIDTH:  window_width_q  <= cfg_data_i;
        CFG_WINDOW_HEIGHT: window_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rssc_front u_front (
    .in_data_i (s_axis_tdata),
    .in_kind_i (s_axis_tuser),
    .in_last_i (s_axis_tlast),
    .entry_o   (front_entry)
  );

  assign s_axis_tready = !queue_full;

  rssc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (s_axis_tvalid && !queue_full),
    .push_entry_i (front_entry),
    .full_o       (queue_full),
    .pop_i        (pop),
    .valid_o      (queue_valid),
    .entry_o      (queue_entry)
  );

  rssc_back #(
    .WORD_OFFSET_BITS (WORD_OFFSET_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .window_width_i  (window_width_q),
    .window_height_i (window_height_q),
    .entry_valid_i   (queue_valid),
    .entry_i         (queue_entry),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_span_o      (span),
    .out_ready_i     (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, span.layer, span.source_word, span.x_end,
                         span.x_start, span.span_y};

endmodule

`default_nettype wire

### src/rssc_front.sv
// Front end: unpacks an input transaction, classifies it and precomputes offsets and sums.
// Depends on rssc_pkg.
`default_nettype none

module rssc_front
  import rssc_pkg::*;
(
  input  wire logic [InDataBits-1:0] in_data_i,
  input  wire logic                  in_kind_i,
  input  wire logic                  in_last_i,
  output rssc_entry_t                entry_o
);

  logic signed [CoordBits-1:0] screen_x, screen_y, origin_x, origin_y;
  logic [SizeBits-1:0]         sprite_w, sprite_h;
  logic signed [PosBits-1:0]   off_x, off_y;

  assign screen_x = in_data_i[15:0];
  assign screen_y = in_data_i[31:16];
  assign origin_x = in_data_i[47:32];
  assign origin_y = in_data_i[63:48];
  assign sprite_w = in_data_i[75:64];
  assign sprite_h = in_data_i[87:76];

  assign off_x = PosBits'(screen_x) - PosBits'(origin_x);
  assign off_y = PosBits'(screen_y) - PosBits'(origin_y);

  always_comb begin
    entry_o.kind    = item_kind_e'(in_kind_i);
    entry_o.off_x   = off_x;
    entry_o.off_y   = off_y;
    entry_o.ext_x   = off_x + PosBits'(signed'({1'b0, sprite_w}));
    entry_o.ext_y   = off_y + PosBits'(signed'({1'b0, sprite_h}));
    entry_o.layer   = in_data_i[95:88];
    entry_o.skip    = in_data_i[107:96];
    entry_o.opq     = in_data_i[119:108];
    entry_o.sum     = {1'b0, in_data_i[107:96]} + {1'b0, in_data_i[119:108]};
    entry_o.row_end = in_last_i;
  end

endmodule

`default_nettype wire

### src/rssc_queue.sv
// Two-entry queue between the front end and the span back end.
// Depends on rssc_pkg.
`default_nettype none

module rssc_queue
  import rssc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire rssc_entry_t push_entry_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output rssc_entry_t entry_o
);

  rssc_entry_t mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> count_q != 2'd0)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

### src/rssc_back.sv
// Back end: sprite and cursor state, span clipping and the output register.
// Depends on rssc_pkg; fed by rssc_queue.
`default_nettype none

module rssc_back
  import rssc_pkg::*;
#(
  parameter int unsigned WORD_OFFSET_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [WinBits-1:0] window_width_i,
  input  wire logic [WinBits-1:0] window_height_i,
  input  wire logic               entry_valid_i,
  input  wire rssc_entry_t        entry_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  output rssc_span_t              out_span_o,
  input  wire logic               out_ready_i
);

  logic                              active_q;
  logic signed [PosBits-1:0]         off_x_q, off_y_q;
  logic signed [SumBits-1:0]         clip_r_q, clip_b_q;
  logic [LayerBits-1:0]              layer_q;
  logic [RowBits-1:0]                row_q;
  logic signed [PosBits-1:0]         cursor_q;
  logic [WORD_OFFSET_BITS-1:0]       row_word_q;
  logic                              out_valid_q;
  rssc_span_t                        out_span_q;

  logic signed [SumBits-1:0] ww_s, wh_s, ext_x, ext_y, clip_r, clip_b, left, top;
  logic signed [SumBits-1:0] y, start, fin, cs, ce, skew;
  logic [WORD_OFFSET_BITS-1:0] src_word;
  logic is_start, is_run, live, emit;

  assign ww_s  = SumBits'(signed'({1'b0, window_width_i}));
  assign wh_s  = SumBits'(signed'({1'b0, window_height_i}));
  assign ext_x = SumBits'(entry_i.ext_x);
  assign ext_y = SumBits'(entry_i.ext_y);

  assign pop_o    = entry_valid_i && (!out_valid_q || out_ready_i);
  assign is_start = pop_o && (entry_i.kind == KIND_START);
  assign is_run   = pop_o && (entry_i.kind == KIND_RUN) && active_q;

  always_comb begin
    clip_r = (ext_x < ww_s) ? ext_x : ww_s;
    clip_b = (ext_y < wh_s) ? ext_y : wh_s;
    left   = entry_i.off_x[PosBits-1] ? '0 : SumBits'(entry_i.off_x);
    top    = entry_i.off_y[PosBits-1] ? '0 : SumBits'(entry_i.off_y);

    y     = SumBits'(off_y_q) + SumBits'(signed'({1'b0, row_q}));
    start = SumBits'(cursor_q) + SumBits'(signed'({1'b0, entry_i.skip}));
    fin   = SumBits'(cursor_q) + SumBits'(signed'({1'b0, entry_i.sum}));
    live  = !y[SumBits-1] && (y < clip_b_q) && (SumBits'(cursor_q) < clip_r_q);
    cs    = start[SumBits-1] ? '0 : start;
    ce    = (fin < ww_s) ? fin : ww_s;
    skew  = start[SumBits-1] ? -start : '0;
    emit  = is_run && (entry_i.opq != '0) && live && (cs < ce);
    src_word = row_word_q + WORD_OFFSET_BITS'(HeaderWords)
             + WORD_OFFSET_BITS'(unsigned'(skew));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      off_x_q    <= '0;
      off_y_q    <= '0;
      clip_r_q   <= '0;
      clip_b_q   <= '0;
      layer_q    <= '0;
      row_q      <= '0;
      cursor_q   <= '0;
      row_word_q <= '0;
    end else if (is_start) begin
      active_q   <= (left < clip_r) && (top < clip_b);
      off_x_q    <= entry_i.off_x;
      off_y_q    <= entry_i.off_y;
      clip_r_q   <= clip_r;
      clip_b_q   <= clip_b;
      layer_q    <= entry_i.layer;
      row_q      <= '0;
      cursor_q   <= entry_i.off_x;
      row_word_q <= '0;
    end else if (is_run) begin
      if (entry_i.row_end) begin
        row_q      <= (row_q != RowMax) ? row_q + 1'b1 : row_q;
        cursor_q   <= off_x_q;
        row_word_q <= '0;
      end else begin
        cursor_q   <= (fin > CursorMax) ? PosBits'(CursorMax) : PosBits'(fin);
        row_word_q <= row_word_q + WORD_OFFSET_BITS'(entry_i.opq)
                    + WORD_OFFSET_BITS'(HeaderWords);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_span_q.span_y      <= y[RowBits-1:0];
      out_span_q.x_start     <= cs[WinBits-1:0];
      out_span_q.x_end       <= ce[WinBits-1:0];
      out_span_q.source_word <= SrcBits'(src_word);
      out_span_q.layer       <= layer_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_span_o  = out_span_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_span_q.x_start < out_span_q.x_end))
    else $error("empty span presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_start |=> (row_q == '0) && (cursor_q == off_x_q) && (row_word_q == '0))
    else $error("sprite start did not rewind cursors");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_run && entry_i.row_end) |=> (row_word_q == '0) && (cursor_q == off_x_q))
    else $error("row end did not rewind cursors");

endmodule

`default_nettype wire
